@@ design/trme_pkg.sv @@
// shared constants, codes and types of the tiny register machine execute core
package trme_pkg;

	localparam int NUM_REGS  = 16;
	localparam int IDX_W     = $clog2(NUM_REGS);
	localparam int DATA_W    = 32;
	localparam int FIELD_W   = 31;
	localparam int DIV_STEPS = DATA_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int SHIFT_W   = $clog2(FIELD_W);

	localparam logic [3:0] OP_MOV = 4'd0;
	localparam logic [3:0] OP_ADD = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_MUL = 4'd3;
	localparam logic [3:0] OP_DIV = 4'd4;
	localparam logic [3:0] OP_GCD = 4'd5;
	localparam logic [3:0] OP_CMP = 4'd6;
	localparam logic [3:0] OP_JMP = 4'd7;
	localparam logic [3:0] OP_BRA = 4'd8;
	localparam logic [3:0] OP_HLT = 4'd9;

	localparam logic [1:0] KIND_IMM = 2'd0;
	localparam logic [1:0] KIND_REG = 2'd1;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_GCD  = 2'd2;
	localparam logic [1:0] ERR_REG  = 2'd3;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		CLS_SIMPLE,
		CLS_MUL,
		CLS_DIV,
		CLS_GCD
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ITER,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic start;
		logic step;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		cls_t cls;
		logic iter_done;
		logic out_free;
	} dp_sts_t;

endpackage

@@ design/trme_regfile.sv @@
// register file memory with per-entry valid bits, two registered read ports
module trme_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [trme_pkg::IDX_W-1:0] rd_addr1,
	input  logic [trme_pkg::IDX_W-1:0] rd_addr2,
	output logic [trme_pkg::DATA_W-1:0] rd_data1,
	output logic [trme_pkg::DATA_W-1:0] rd_data2,
	input  logic                       wr_en,
	input  logic [trme_pkg::IDX_W-1:0] wr_addr,
	input  logic [trme_pkg::DATA_W-1:0] wr_data
);
	import trme_pkg::*;

	logic [DATA_W-1:0]   mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [DATA_W-1:0]   rd1_q;
	logic [DATA_W-1:0]   rd2_q;
	logic                rd_vld1_q;
	logic                rd_vld2_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd1_q <= mem_q[rd_addr1];
			rd2_q <= mem_q[rd_addr2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld1_q <= 1'b0;
			rd_vld2_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld1_q <= vld_q[rd_addr1];
				rd_vld2_q <= vld_q[rd_addr2];
			end
		end
	end

	assign rd_data1 = rd_vld1_q ? rd1_q : '0;
	assign rd_data2 = rd_vld2_q ? rd2_q : '0;

endmodule

@@ design/trme_datapath.sv @@
// operand fetch, decode, alu, iterative divider and gcd unit, result register
module trme_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trme_pkg::ctl_cmd_t            cmd_ctl,
	output trme_pkg::dp_sts_t             sts,
	input  logic [3:0]                    cmd,
	input  logic [1:0]                    src1_kind,
	input  logic [trme_pkg::FIELD_W-1:0]  src1_field,
	input  logic [1:0]                    src2_kind,
	input  logic [trme_pkg::FIELD_W-1:0]  src2_field,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [trme_pkg::DATA_W-1:0] r0_value,
	output logic                          jump_taken,
	output logic [trme_pkg::FIELD_W-1:0]  jump_target,
	output logic                          halted,
	output logic [1:0]                    error_code
);
	import trme_pkg::*;

	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r = v[DATA_W] ? S32_MIN : S32_MAX;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat64(input logic signed [2*DATA_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if ((&v[2*DATA_W-1:DATA_W-1]) || !(|v[2*DATA_W-1:DATA_W-1])) begin
			r = v[DATA_W-1:0];
		end else begin
			r = v[2*DATA_W-1] ? S32_MIN : S32_MAX;
		end
		return r;
	endfunction

	// captured item
	logic [3:0]         cmd_q;
	logic [1:0]         k1_q;
	logic [1:0]         k2_q;
	logic [FIELD_W-1:0] f1_q;
	logic [FIELD_W-1:0] f2_q;

	// architectural state
	logic signed [DATA_W-1:0] r0_q;
	logic                     halt_q;

	// decoded plan
	cls_t                     cls_q;
	logic [1:0]               err_q;
	logic                     wr_en_q;
	logic [IDX_W-1:0]         wr_addr_q;
	logic signed [DATA_W-1:0] res_q;
	logic                     taken_q;
	logic [FIELD_W-1:0]       target_q;
	logic                     set_halt_q;
	logic signed [2*DATA_W-1:0] prod_s1;

	// divider
	logic [DATA_W-1:0] n_q;
	logic [DATA_W-1:0] d_q;
	logic [DATA_W-1:0] rem_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;

	// gcd
	logic [FIELD_W-1:0] x_q;
	logic [FIELD_W-1:0] y_q;
	logic [SHIFT_W-1:0] k_q;

	// output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] r0_value_q;
	logic                     jump_taken_q;
	logic [FIELD_W-1:0]       jump_target_q;
	logic                     halted_q;
	logic [1:0]               error_code_q;

	logic [DATA_W-1:0]        rd1;
	logic [DATA_W-1:0]        rd2;
	logic signed [DATA_W-1:0] opa;
	logic signed [DATA_W-1:0] opb;
	logic                     bad1;
	logic                     bad2;
	logic                     active;
	logic [1:0]               dec_err;
	cls_t                     dec_cls;
	logic                     dec_wr;
	logic signed [DATA_W-1:0] dec_res;
	logic                     dec_taken;
	logic [FIELD_W-1:0]       dec_target;
	logic signed [DATA_W:0]   sum;
	logic signed [DATA_W:0]   diff;
	logic signed [2*DATA_W-1:0] prod;

	logic [DATA_W:0]          rem_sh;
	logic [DATA_W:0]          rem_sub;
	logic signed [DATA_W-1:0] div_res;
	logic signed [DATA_W-1:0] gcd_res;
	logic signed [DATA_W-1:0] wr_data;
	logic                     wr_fire;

	trme_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (cmd_ctl.capture),
		.rd_addr1 (src1_field[IDX_W-1:0]),
		.rd_addr2 (src2_field[IDX_W-1:0]),
		.rd_data1 (rd1),
		.rd_data2 (rd2),
		.wr_en    (wr_fire),
		.wr_addr  (wr_addr_q),
		.wr_data  (wr_data)
	);

	always_ff @(posedge clk) begin
		if (cmd_ctl.capture) begin
			cmd_q <= cmd;
			k1_q  <= src1_kind;
			k2_q  <= src2_kind;
			f1_q  <= src1_field;
			f2_q  <= src2_field;
		end
	end

	// operand select and decode
	always_comb begin
		case (k1_q)
			KIND_IMM: opa = {1'b0, f1_q};
			KIND_REG: opa = rd1;
			default:  opa = '0;
		endcase
		case (k2_q)
			KIND_IMM: opb = {1'b0, f2_q};
			KIND_REG: opb = rd2;
			default:  opb = '0;
		endcase

		bad1   = (cmd_q != OP_HLT) && (k1_q == KIND_REG) && (f1_q >= FIELD_W'(NUM_REGS));
		bad2   = (cmd_q <= OP_CMP) && (k2_q == KIND_REG) && (f2_q >= FIELD_W'(NUM_REGS));
		active = !halt_q && (cmd_q <= OP_HLT);

		sum  = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
		diff = {opa[DATA_W-1], opa} - {opb[DATA_W-1], opb};
		prod = opa * opb;

		dec_err = ERR_NONE;
		if (active) begin
			if (bad1 || bad2) begin
				dec_err = ERR_REG;
			end else if (cmd_q == OP_MOV && !(k1_q == KIND_REG && k2_q == KIND_REG)) begin
				dec_err = ERR_REG;
			end else if (cmd_q == OP_DIV && opb == '0) begin
				dec_err = ERR_DIV0;
			end else if (cmd_q == OP_GCD && opa != opb && !(opa > 0 && opb > 0)) begin
				dec_err = ERR_GCD;
			end
		end

		dec_cls = CLS_SIMPLE;
		if (active && dec_err == ERR_NONE) begin
			case (cmd_q)
				OP_MUL:  dec_cls = CLS_MUL;
				OP_DIV:  dec_cls = CLS_DIV;
				OP_GCD:  dec_cls = (opa != opb) ? CLS_GCD : CLS_SIMPLE;
				default: dec_cls = CLS_SIMPLE;
			endcase
		end

		dec_wr = active && (dec_err == ERR_NONE) && (cmd_q inside {[OP_MOV:OP_CMP]});

		case (cmd_q)
			OP_MOV:  dec_res = opb;
			OP_ADD:  dec_res = sat33(sum);
			OP_SUB:  dec_res = sat33(diff);
			OP_CMP:  dec_res = (opa < opb) ? 32'sd1 : 32'sd0;
			default: dec_res = opa;
		endcase

		dec_taken = active && (dec_err == ERR_NONE)
			&& ((cmd_q == OP_JMP) || (cmd_q == OP_BRA && r0_q == 32'sd1));
		dec_target = (dec_taken && !opa[DATA_W-1]) ? opa[FIELD_W-1:0] : '0;
	end

	// divider step
	always_comb begin
		rem_sh  = {rem_q, n_q[DATA_W-1]};
		rem_sub = rem_sh - {1'b0, d_q};
	end

	always_comb begin
		if (neg_q) begin
			div_res = -n_q;
		end else begin
			div_res = n_q[DATA_W-1] ? S32_MAX : n_q;
		end
		gcd_res = DATA_W'({1'b0, x_q} << k_q);
		case (cls_q)
			CLS_MUL: wr_data = sat64(prod_s1);
			CLS_DIV: wr_data = div_res;
			CLS_GCD: wr_data = gcd_res;
			default: wr_data = res_q;
		endcase
	end

	assign wr_fire = cmd_ctl.commit && wr_en_q;

	always_ff @(posedge clk) begin
		if (cmd_ctl.start) begin
			cls_q      <= dec_cls;
			err_q      <= dec_err;
			wr_en_q    <= dec_wr;
			wr_addr_q  <= (cmd_q == OP_MOV) ? f1_q[IDX_W-1:0] : '0;
			res_q      <= dec_res;
			taken_q    <= dec_taken;
			target_q   <= dec_target;
			set_halt_q <= active && (cmd_q == OP_HLT);
			prod_s1    <= prod;
			n_q        <= opa[DATA_W-1] ? DATA_W'(-opa) : opa;
			d_q        <= opb[DATA_W-1] ? DATA_W'(-opb) : opb;
			rem_q      <= '0;
			neg_q      <= opa[DATA_W-1] ^ opb[DATA_W-1];
			cnt_q      <= '0;
			x_q        <= opa[FIELD_W-1:0];
			y_q        <= opb[FIELD_W-1:0];
			k_q        <= '0;
		end else if (cmd_ctl.step) begin
			if (cls_q == CLS_DIV) begin
				if (!rem_sub[DATA_W]) begin
					rem_q <= rem_sub[DATA_W-1:0];
					n_q   <= {n_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DATA_W-1:0];
					n_q   <= {n_q[DATA_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end else if (x_q != y_q) begin
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q > y_q) begin
					x_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_ctl.commit) begin
				if (wr_en_q && wr_addr_q == '0) begin
					r0_q <= wr_data;
				end
				if (set_halt_q) begin
					halt_q <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ctl.commit) begin
			r0_value_q    <= (wr_en_q && wr_addr_q == '0) ? wr_data : r0_q;
			jump_taken_q  <= taken_q;
			jump_target_q <= target_q;
			halted_q      <= halt_q || set_halt_q;
			error_code_q  <= err_q;
		end
	end

	always_comb begin
		sts.cls       = dec_cls;
		sts.iter_done = (cls_q == CLS_DIV) ? (cnt_q == CNT_W'(DIV_STEPS - 1)) : (x_q == y_q);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign r0_value    = r0_value_q;
	assign jump_taken  = jump_taken_q;
	assign jump_target = jump_target_q;
	assign halted      = halted_q;
	assign error_code  = error_code_q;

endmodule

@@ design/trme_ctrl.sv @@
// controller state machine sequencing accept, decode, iteration and commit
module trme_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  trme_pkg::dp_sts_t  sts,
	output trme_pkg::ctl_cmd_t cmd_ctl
);
	import trme_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_ctl  = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd_ctl.capture = 1'b1;
					state_d         = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd_ctl.start = 1'b1;
				if (sts.cls == CLS_DIV || sts.cls == CLS_GCD) begin
					state_d = ST_ITER;
				end else begin
					state_d = ST_COMMIT;
				end
			end
			ST_ITER: begin
				cmd_ctl.step = 1'b1;
				if (sts.iter_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd_ctl.commit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/tiny_register_machine_execute_core.sv @@
// top level of the tiny register machine execute core
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  cmd, src1_kind, src1_field, src2_kind, src2_field
// out      output     out_valid / out_stall r0_value, jump_taken, jump_target, halted, error_code
//
// one item at a time: accept, decode, optional iteration, commit, back to idle
// simple ops and mul go straight from decode to commit; div adds 32 divider steps (one quotient bit each)
// gcd adds up to 60 binary gcd steps, set by the operand bit lengths
// reset clears the register file valid bits, r0, the halt flag and the output valid flag
// a stalled result holds in the output register; the next item is accepted meanwhile
module tiny_register_machine_execute_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [3:0]                    cmd,
	input  logic [1:0]                    src1_kind,
	input  logic [trme_pkg::FIELD_W-1:0]  src1_field,
	input  logic [1:0]                    src2_kind,
	input  logic [trme_pkg::FIELD_W-1:0]  src2_field,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [trme_pkg::DATA_W-1:0] r0_value,
	output logic                          jump_taken,
	output logic [trme_pkg::FIELD_W-1:0]  jump_target,
	output logic                          halted,
	output logic [1:0]                    error_code
);
	import trme_pkg::*;

	ctl_cmd_t cmd_ctl;
	dp_sts_t  sts;

	trme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd_ctl  (cmd_ctl)
	);

	trme_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_ctl     (cmd_ctl),
		.sts         (sts),
		.cmd         (cmd),
		.src1_kind   (src1_kind),
		.src1_field  (src1_field),
		.src2_kind   (src2_kind),
		.src2_field  (src2_field),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.r0_value    (r0_value),
		.jump_taken  (jump_taken),
		.jump_target (jump_target),
		.halted      (halted),
		.error_code  (error_code)
	);

endmodule

@@ dv/tiny_register_machine_execute_core_test.sv @@
// self-checking testbench of the tiny register machine execute core
`timescale 1ns / 1ps

module tiny_register_machine_execute_core_test;
	import trme_pkg::*;

	localparam logic [1:0] KIND_BAD  = 2'd2;
	localparam logic [1:0] KIND_RSVD = 2'd3;
	localparam logic [3:0] OP_UNDEF  = 4'd12;
	localparam int RAND_ITEMS  = 1080;
	localparam int AFTER_HALT  = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;

	typedef struct packed {
		logic [1:0]         kind;
		logic [FIELD_W-1:0] field;
	} operand_t;

	typedef struct packed {
		logic [3:0] op;
		operand_t   src1;
		operand_t   src2;
	} instr_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] r0;
		logic                     taken;
		logic [FIELD_W-1:0]       target;
		logic                     halted;
		logic [1:0]               err;
	} outcome_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] val;
	} fetched_t;

	typedef struct packed {
		instr_t   ins;
		logic     typed;
		outcome_t want;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [3:0] cmd;
	logic [1:0] src1_kind, src2_kind;
	logic [FIELD_W-1:0] src1_field, src2_field;
	logic signed [DATA_W-1:0] r0_value;
	logic jump_taken;
	logic [FIELD_W-1:0] jump_target;
	logic halted;
	logic [1:0] error_code;

	logic signed [DATA_W-1:0] gold_regs [NUM_REGS];
	logic gold_halt;
	outcome_t pending_results[$];
	row_t dir_tab[$];
	bit idle_on;
	bit hold_go;
	int unsigned mismatch_count;
	int unsigned results_seen;

	tiny_register_machine_execute_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.src1_kind  (src1_kind),
		.src1_field (src1_field),
		.src2_kind  (src2_kind),
		.src2_field (src2_field),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.r0_value   (r0_value),
		.jump_taken (jump_taken),
		.jump_target(jump_target),
		.halted     (halted),
		.error_code (error_code)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
		if (v > longint'(S32_MAX))
			return S32_MAX;
		if (v < longint'(S32_MIN))
			return S32_MIN;
		return v[DATA_W-1:0];
	endfunction

	function automatic fetched_t fetch_operand(input operand_t opnd);
		fetched_t r;
		r.ok = 1'b1;
		r.val = '0;
		if (opnd.kind == KIND_IMM) begin
			r.val = {1'b0, opnd.field};
		end else if (opnd.kind == KIND_REG) begin
			if (opnd.field >= NUM_REGS)
				r.ok = 1'b0;
			else
				r.val = gold_regs[opnd.field[IDX_W-1:0]];
		end
		return r;
	endfunction

	function automatic outcome_t exec_instr(input instr_t i);
		outcome_t o;
		fetched_t a, b;
		int unsigned x, y, t;
		o = '0;
		a = '{ok: 1'b1, val: '0};
		b = '{ok: 1'b1, val: '0};
		if (!gold_halt && i.op <= OP_HLT) begin
			if (i.op != OP_HLT)
				a = fetch_operand(i.src1);
			if (i.op <= OP_CMP)
				b = fetch_operand(i.src2);
			if (!a.ok || !b.ok) begin
				o.err = ERR_REG;
			end else begin
				case (i.op)
					OP_MOV: begin
						if (i.src1.kind != KIND_REG || i.src2.kind != KIND_REG)
							o.err = ERR_REG;
						else
							gold_regs[i.src1.field[IDX_W-1:0]] =
								gold_regs[i.src2.field[IDX_W-1:0]];
					end
					OP_ADD: gold_regs[0] = clamp32(longint'(a.val) + longint'(b.val));
					OP_SUB: gold_regs[0] = clamp32(longint'(a.val) - longint'(b.val));
					OP_MUL: gold_regs[0] = clamp32(longint'(a.val) * longint'(b.val));
					OP_DIV: begin
						if (b.val == 0)
							o.err = ERR_DIV0;
						else
							gold_regs[0] = clamp32(longint'(a.val) / longint'(b.val));
					end
					OP_GCD: begin
						if (a.val == b.val) begin
							gold_regs[0] = a.val;
						end else if (a.val > 0 && b.val > 0) begin
							x = a.val;
							y = b.val;
							while (y != 0) begin
								t = x % y;
								x = y;
								y = t;
							end
							gold_regs[0] = x;
						end else begin
							o.err = ERR_GCD;
						end
					end
					OP_CMP: gold_regs[0] = (a.val < b.val) ? 1 : 0;
					OP_JMP, OP_BRA: begin
						if (i.op == OP_JMP || gold_regs[0] == 1) begin
							o.taken = 1'b1;
							o.target = (a.val < 0) ? '0 : a.val[FIELD_W-1:0];
						end
					end
					OP_HLT: gold_halt = 1'b1;
					default: ;
				endcase
			end
		end
		o.r0 = gold_regs[0];
		o.halted = gold_halt;
		return o;
	endfunction

	function automatic operand_t rand_operand();
		operand_t r;
		int unsigned p;
		p = $urandom_range(99);
		r.field = FIELD_W'($urandom);
		if (p < 50) begin
			r.kind = KIND_REG;
			if (p < 15)
				r.field = '0;
			else if (p < 46)
				r.field = FIELD_W'($urandom_range(NUM_REGS - 1));
			else if (p[0])
				r.field = FIELD_W'(NUM_REGS + $urandom_range(15));
		end else if (p < 85) begin
			r.kind = KIND_IMM;
			case ($urandom_range(3))
				0: r.field = FIELD_W'($urandom_range(20));
				1: r.field = FIELD_W'($urandom_range(2000));
				2: r.field = p[0] ? '1 : '0;
				default: ;
			endcase
		end else begin
			r.kind = (p < 93) ? KIND_BAD : KIND_RSVD;
		end
		return r;
	endfunction

	function automatic instr_t rand_instr();
		instr_t i;
		int unsigned p;
		p = $urandom_range(99);
		if (p < 20)
			i.op = OP_MOV;
		else if (p < 96)
			i.op = 4'($urandom_range(OP_BRA, OP_ADD));
		else
			i.op = 4'($urandom_range(15, OP_HLT + 1));
		i.src1 = rand_operand();
		i.src2 = rand_operand();
		// mostly well-formed moves so the whole register file gets filled
		if (i.op == OP_MOV && $urandom_range(9) < 8) begin
			i.src1 = '{kind: KIND_REG, field: FIELD_W'($urandom_range(NUM_REGS - 1))};
			i.src2 = '{kind: KIND_REG, field: FIELD_W'($urandom_range(NUM_REGS - 1))};
		end
		return i;
	endfunction

	function automatic instr_t mk_instr(input logic [3:0] op,
			input logic [1:0] k1, input logic [FIELD_W-1:0] f1,
			input logic [1:0] k2, input logic [FIELD_W-1:0] f2);
		instr_t i;
		i.op = op;
		i.src1 = '{kind: k1, field: f1};
		i.src2 = '{kind: k2, field: f2};
		return i;
	endfunction

	function automatic outcome_t mk_out(input logic signed [DATA_W-1:0] r0,
			input logic taken, input logic [FIELD_W-1:0] target, input logic [1:0] err);
		outcome_t o;
		o.r0 = r0;
		o.taken = taken;
		o.target = target;
		o.halted = 1'b0;
		o.err = err;
		return o;
	endfunction

	task automatic put(input instr_t ins, input logic typed, input outcome_t want);
		row_t r;
		r.ins = ins;
		r.typed = typed;
		r.want = want;
		dir_tab.push_back(r);
	endtask

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] result %0d: %s", $time, results_seen, msg);
	endtask

	task automatic offer_item(input instr_t ins, input logic typed, input outcome_t want);
		outcome_t calc;
		while (idle_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= ins.op;
		src1_kind  <= ins.src1.kind;
		src1_field <= ins.src1.field;
		src2_kind  <= ins.src2.kind;
		src2_field <= ins.src2.field;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		calc = exec_instr(ins);
		pending_results.push_back(typed ? want : calc);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with no item pending");
			end else begin
				want = pending_results.pop_front();
				if (r0_value !== want.r0)
					note_mismatch($sformatf("r0_value %0d, want %0d", r0_value, want.r0));
				if (jump_taken !== want.taken)
					note_mismatch($sformatf("jump_taken %b, want %b", jump_taken, want.taken));
				if (jump_target !== want.target)
					note_mismatch($sformatf("jump_target %0d, want %0d",
						jump_target, want.target));
				if (halted !== want.halted)
					note_mismatch($sformatf("halted %b, want %b", halted, want.halted));
				if (error_code !== want.err)
					note_mismatch($sformatf("error_code %0d, want %0d", error_code, want.err));
			end
			results_seen++;
		end
	end

	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			// long hold-off so the core fills up and stalls its input
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= idle_on && ($urandom_range(99) < 36);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int n;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = OP_MOV;
		src1_kind  = KIND_IMM;
		src1_field = '0;
		src2_kind  = KIND_IMM;
		src2_field = '0;
		idle_on    = 1'b1;
		hold_go    = 1'b0;
		mismatch_count = 0;
		results_seen   = 0;
		foreach (gold_regs[r])
			gold_regs[r] = '0;
		gold_halt = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put(mk_instr(OP_ADD, KIND_IMM, '1, KIND_IMM, '1), 1, mk_out(S32_MAX, 0, 0, ERR_NONE));
		put(mk_instr(OP_MOV, KIND_REG, 1, KIND_REG, 0), 1, mk_out(S32_MAX, 0, 0, ERR_NONE));
		put(mk_instr(OP_SUB, KIND_IMM, 0, KIND_IMM, '1), 1,
			mk_out(32'sh8000_0001, 0, 0, ERR_NONE));
		put(mk_instr(OP_SUB, KIND_REG, 0, KIND_IMM, 1), 1, mk_out(S32_MIN, 0, 0, ERR_NONE));
		put(mk_instr(OP_SUB, KIND_REG, 0, KIND_IMM, 1), 1, mk_out(S32_MIN, 0, 0, ERR_NONE));
		put(mk_instr(OP_MOV, KIND_REG, 3, KIND_REG, 0), 1, mk_out(S32_MIN, 0, 0, ERR_NONE));
		put(mk_instr(OP_SUB, KIND_IMM, 0, KIND_IMM, 1), 1, mk_out(-1, 0, 0, ERR_NONE));
		put(mk_instr(OP_MOV, KIND_REG, 2, KIND_REG, 0), 1, mk_out(-1, 0, 0, ERR_NONE));
		put(mk_instr(OP_DIV, KIND_REG, 3, KIND_REG, 2), 1, mk_out(S32_MAX, 0, 0, ERR_NONE));
		put(mk_instr(OP_MUL, KIND_REG, 1, KIND_REG, 3), 1, mk_out(S32_MIN, 0, 0, ERR_NONE));
		put(mk_instr(OP_DIV, KIND_IMM, 7, KIND_BAD, 123), 1, mk_out(S32_MIN, 0, 0, ERR_DIV0));
		put(mk_instr(OP_GCD, KIND_IMM, 0, KIND_IMM, 5), 1, mk_out(S32_MIN, 0, 0, ERR_GCD));
		put(mk_instr(OP_GCD, KIND_REG, 2, KIND_REG, 2), 1, mk_out(-1, 0, 0, ERR_NONE));
		put(mk_instr(OP_GCD, KIND_IMM, 1071, KIND_IMM, 462), 1, mk_out(21, 0, 0, ERR_NONE));
		put(mk_instr(OP_CMP, KIND_REG, 3, KIND_REG, 1), 1, mk_out(1, 0, 0, ERR_NONE));
		// negative register target clips to line zero
		put(mk_instr(OP_BRA, KIND_REG, 2, KIND_RSVD, '1), 1, mk_out(1, 1, 0, ERR_NONE));
		// unused second operand with a bad index raises nothing
		put(mk_instr(OP_JMP, KIND_IMM, '1, KIND_REG, '1), 1, mk_out(1, 1, '1, ERR_NONE));
		put(mk_instr(OP_ADD, KIND_REG, '1, KIND_IMM, 1), 1, mk_out(1, 0, 0, ERR_REG));
		put(mk_instr(OP_MOV, KIND_IMM, 4, KIND_REG, 0), 1, mk_out(1, 0, 0, ERR_REG));
		put(mk_instr(OP_MOV, KIND_REG, 5, KIND_REG, FIELD_W'(NUM_REGS)), 1,
			mk_out(1, 0, 0, ERR_REG));
		put(mk_instr(OP_UNDEF, KIND_REG, '1, KIND_BAD, '1), 1, mk_out(1, 0, 0, ERR_NONE));
		put(mk_instr(OP_DIV, KIND_REG, 3, KIND_IMM, 7), 0, '0);
		put(mk_instr(OP_BRA, KIND_IMM, 55, KIND_IMM, 0), 0, '0);
		put(mk_instr(OP_JMP, KIND_RSVD, 99, KIND_IMM, 0), 0, '0);
		put(mk_instr(OP_CMP, KIND_RSVD, 1, KIND_BAD, 2), 1, mk_out(0, 0, 0, ERR_NONE));
		foreach (dir_tab[r])
			offer_item(dir_tab[r].ins, dir_tab[r].typed, dir_tab[r].want);

		for (n = 0; n < RAND_ITEMS; n++) begin
			idle_on = (n < 300 || n >= 480);
			if (n == 700)
				hold_go = 1'b1;
			offer_item(rand_instr(), 1'b0, '0);
		end

		// halt ignores its operands, then everything after it is a no-op
		offer_item(mk_instr(OP_HLT, KIND_REG, '1, KIND_REG, '1), 1'b0, '0);
		repeat (AFTER_HALT) offer_item(rand_instr(), 1'b0, '0);
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
